### src/rmcw_pkg.sv
package rmcw_pkg;

  // input word kinds carried on tuser
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FAST  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_X_START = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_START = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_END   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_END   = 4'd3;

  localparam logic signed [11:0] RST_X_START = 12'sd0;
  localparam logic signed [11:0] RST_Y_START = 12'sd0;
  localparam logic signed [11:0] RST_X_END   = 12'sd256;
  localparam logic signed [11:0] RST_Y_END   = 12'sd128;

  // largest window span the 11-bit counters cover
  localparam logic [11:0] MAX_SPAN = 12'd2048;

  localparam logic [17:0] BLACK_LIMIT = 18'd150000;

  typedef struct packed {
    logic              empty;
    logic              first_anchor;
    logic              last;
    logic              frame_ok;
    logic signed [12:0] dx;
    logic signed [12:0] dy;
  } win_status_t;

  // weighted luma test, white and black take the shortcut
  function automatic logic pixel_black(input logic [15:0] p);
    logic [17:0] s;
    s = 18'(p[15:11]) * 18'd2460 + 18'(p[10:5]) * 18'd2376 + 18'(p[4:0]) * 18'd938;
    if (p == 16'hFFFF) begin
      return 1'b0;
    end
    if (p == 16'h0000) begin
      return 1'b1;
    end
    return s < BLACK_LIMIT;
  endfunction

endpackage

### src/rmcw_canvas_ram.sv
module rmcw_canvas_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] ra,
  output logic [7:0]    rd_q,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [7:0]    wd
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_q_r <= mem[ra];
    end
  end

  assign rd_q = rd_q_r;

endmodule

### src/rmcw_window.sv
module rmcw_window #(
  parameter int CANVAS_WIDTH  = 256,
  parameter int CANVAS_HEIGHT = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rmcw_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [11:0]                    cfg_data,
  input  logic                           step,
  output rmcw_pkg::win_status_t          st
);

  import rmcw_pkg::*;

  logic signed [11:0] xs_r, ys_r, xe_r, ye_r;
  logic signed [11:0] xs_nxt, ys_nxt, xe_nxt, ye_nxt;
  logic [10:0]        col_r, row_r, col_nxt, row_nxt;
  logic signed [12:0] dw, dh;
  logic [11:0]        w, h, col_inc, row_inc;
  logic               col_end, row_end;

  assign dw = {xe_r[11], xe_r} - {xs_r[11], xs_r};
  assign dh = {ye_r[11], ye_r} - {ys_r[11], ys_r};

  // span clamped to the counter range
  always_comb begin
    if (dw <= 13'sd0) begin
      w = '0;
    end else if (dw > $signed({1'b0, MAX_SPAN})) begin
      w = MAX_SPAN;
    end else begin
      w = dw[11:0];
    end
    if (dh <= 13'sd0) begin
      h = '0;
    end else if (dh > $signed({1'b0, MAX_SPAN})) begin
      h = MAX_SPAN;
    end else begin
      h = dh[11:0];
    end
  end

  assign col_inc = {1'b0, col_r} + 12'd1;
  assign row_inc = {1'b0, row_r} + 12'd1;
  assign col_end = col_inc >= w;
  assign row_end = row_inc >= h;

  assign st.empty        = (w == '0) || (h == '0);
  assign st.first_anchor = (col_r == '0) && (row_r == '0) && (xs_r == '0) && (ys_r == '0);
  assign st.last         = col_end && row_end;
  assign st.frame_ok     = (xs_r <= 12'sd0) && (xe_r >= $signed(12'(CANVAS_WIDTH)))
                           && (ye_r >= $signed(12'(CANVAS_HEIGHT)));
  assign st.dx           = {xs_r[11], xs_r} + $signed({2'b00, col_r});
  assign st.dy           = {ys_r[11], ys_r} + $signed({2'b00, row_r});

  always_comb begin
    xs_nxt  = xs_r;
    ys_nxt  = ys_r;
    xe_nxt  = xe_r;
    ye_nxt  = ye_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_X_START: begin
          xs_nxt  = cfg_data;
          col_nxt = '0;
          row_nxt = '0;
        end
        REG_Y_START: begin
          ys_nxt  = cfg_data;
          col_nxt = '0;
          row_nxt = '0;
        end
        REG_X_END: begin
          xe_nxt  = cfg_data;
          col_nxt = '0;
          row_nxt = '0;
        end
        REG_Y_END: begin
          ye_nxt  = cfg_data;
          col_nxt = '0;
          row_nxt = '0;
        end
        default: ;
      endcase
    end else if (step) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_inc[10:0];
      end else begin
        col_nxt = col_inc[10:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xs_r  <= RST_X_START;
      ys_r  <= RST_Y_START;
      xe_r  <= RST_X_END;
      ye_r  <= RST_Y_END;
      col_r <= '0;
      row_r <= '0;
    end else begin
      xs_r  <= xs_nxt;
      ys_r  <= ys_nxt;
      xe_r  <= xe_nxt;
      ye_r  <= ye_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### src/rgb565_to_mono_canvas_writer.sv
// rgb565 pixel stream to 1-bit-per-pixel canvas
//
// in channel: one word per op. tuser holds the op: write pixel, read canvas
// byte, or arm fast refresh. pixels arrive in raster order for the window set
// through the cfg channel (x start, y start, x end, y end; a write to one of
// them restarts the window). out channel: read replies (tuser 1) and window-done words
// (tuser 0) carrying the frame update and fast refresh flags.
//
// steps: a pixel write goes accept, canvas read, modify/write; a byte read
// goes accept, reply; an arm is done at accept. the canvas byte memory has one
// read and one write port with a registered read, and its read-modify-write
// sequence sets the pixel rate. the first pixel of a window anchored at the
// origin sweeps the canvas to white first. reset: the same sweep runs with
// in_tready low; cfg writes are taken at any time.
// stall: results sit in an output register; new words are still taken while
// a result waits, and an item that owes a result holds in its last step
// until the output register frees.
module rgb565_to_mono_canvas_writer #(
  parameter int CANVAS_WIDTH  = 256,
  parameter int CANVAS_HEIGHT = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rmcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]                    cfg_data,
  // input words
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,  // pixel[15:0], read_addr[27:16], zero pad
  input  logic [1:0]                     in_tuser,  // op[1:0]
  // result words
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata, // read_data[7:0], frame_update[8],
                                                    // fast_refresh[9], zero pad
  output logic                           out_tuser  // is_read
);

  import rmcw_pkg::*;

  localparam int STRIDE       = (CANVAS_WIDTH + 7) / 8;
  localparam int CANVAS_BYTES = STRIDE * CANVAS_HEIGHT;
  localparam int ADDR_W       = (CANVAS_BYTES > 1) ? $clog2(CANVAS_BYTES) : 1;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(CANVAS_BYTES - 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_RDOUT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              pend_r, pend_nxt;
  logic              fast_r, fast_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_is_read_r, out_is_read_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_upd_r, out_upd_nxt;
  logic              out_fast_r, out_fast_nxt;

  // per-item payload
  logic [15:0]        pix_r;
  logic signed [12:0] dx_r, dy_r;
  logic               last_r, frame_ok_r, oob_r;
  logic               inb_r, black_r;
  logic [7:0]         mask_r;
  logic [ADDR_W-1:0]  idx_r;

  logic               in_acc, out_free, win_step, cfg_we;
  logic [1:0]         in_op;
  logic [15:0]        in_pixel;
  logic [11:0]        in_read_addr;
  logic               rd_in_range;
  win_status_t        st;

  logic               inb;
  logic [ADDR_W-1:0]  idx;
  logic [7:0]         mask;

  logic               mem_re, mem_we;
  logic [ADDR_W-1:0]  mem_ra, mem_wa;
  logic [7:0]         mem_q, mem_wd;

  assign in_op        = in_tuser;
  assign in_pixel     = in_tdata[15:0];
  assign in_read_addr = in_tdata[27:16];
  assign rd_in_range  = {20'd0, in_read_addr} < 32'(CANVAS_BYTES);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  rmcw_window #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_index),
    .cfg_data(cfg_data),
    .step    (win_step),
    .st      (st)
  );

  // canvas position of the pending pixel
  assign inb  = !dx_r[12] && (dx_r < $signed(13'(CANVAS_WIDTH)))
                && !dy_r[12] && (dy_r < $signed(13'(CANVAS_HEIGHT)));
  assign idx  = ADDR_W'(32'(dy_r[11:0]) * STRIDE + 32'(dx_r[11:3]));
  assign mask = 8'h80 >> dx_r[2:0];

  // memory ports; the next item enters only after the write step,
  // so a read never sees a byte with a write still in flight
  assign mem_re = (in_acc && (in_op == OP_READ)) || (state_r == S_ADDR);
  assign mem_ra = (state_r == S_ADDR) ? idx : ADDR_W'(in_read_addr);
  assign mem_we = (state_r == S_CLEAR) || ((state_r == S_WR) && inb_r);
  assign mem_wa = (state_r == S_CLEAR) ? clr_cnt_r : idx_r;
  assign mem_wd = (state_r == S_CLEAR) ? 8'hFF
                : (black_r ? (mem_q & ~mask_r) : (mem_q | mask_r));

  rmcw_canvas_ram #(
    .DEPTH(CANVAS_BYTES),
    .AW   (ADDR_W)
  ) u_canvas (
    .clk (clk),
    .re  (mem_re),
    .ra  (mem_ra),
    .rd_q(mem_q),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd)
  );

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    pend_nxt        = pend_r;
    fast_nxt        = fast_r;
    win_step        = 1'b0;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_is_read_nxt = out_is_read_r;
    out_data_nxt    = out_data_r;
    out_upd_nxt     = out_upd_r;
    out_fast_nxt    = out_fast_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          clr_cnt_nxt = '0;
          pend_nxt    = 1'b0;
          state_nxt   = pend_r ? S_ADDR : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_WRITE: begin
              // empty window drops the pixel
              if (!st.empty) begin
                win_step  = 1'b1;
                pend_nxt  = st.first_anchor;
                state_nxt = st.first_anchor ? S_CLEAR : S_ADDR;
              end
            end
            OP_READ:  state_nxt = S_RDOUT;
            OP_FAST:  fast_nxt = 1'b1;
            default:  ;
          endcase
        end
      end
      S_ADDR: state_nxt = S_WR;
      S_WR: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_is_read_nxt = 1'b0;
          out_data_nxt    = 8'h00;
          out_upd_nxt     = frame_ok_r;
          out_fast_nxt    = frame_ok_r && fast_r;
          if (frame_ok_r) begin
            fast_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_RDOUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_is_read_nxt = 1'b1;
          out_data_nxt    = oob_r ? 8'hFF : mem_q;
          out_upd_nxt     = 1'b0;
          out_fast_nxt    = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      fast_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      fast_r      <= fast_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    out_is_read_r <= out_is_read_nxt;
    out_data_r    <= out_data_nxt;
    out_upd_r     <= out_upd_nxt;
    out_fast_r    <= out_fast_nxt;
    if (in_acc) begin
      pix_r      <= in_pixel;
      dx_r       <= st.dx;
      dy_r       <= st.dy;
      last_r     <= st.last;
      frame_ok_r <= st.frame_ok;
      oob_r      <= !rd_in_range;
    end
    if (state_r == S_ADDR) begin
      inb_r   <= inb;
      idx_r   <= idx;
      mask_r  <= mask;
      black_r <= pixel_black(pix_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_is_read_r;
  assign out_tdata  = {6'd0, out_fast_r, out_upd_r, out_data_r};

`ifndef SYNTH
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_wa) < 32'(CANVAS_BYTES)))
    else $error("canvas write out of range");

  a_read_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == OP_READ)) |=> (state_r == S_RDOUT))
    else $error("read did not reach reply step");

  a_fast_needs_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fast_r) |-> (out_upd_r && !out_is_read_r))
    else $error("fast refresh without frame update");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!in_tready && mem_we))
    else $error("clear sweep not exclusive");
`endif

endmodule

### tb/rgb565_to_mono_canvas_writer_tb.sv
module rgb565_to_mono_canvas_writer_tb;
  import rmcw_pkg::*;

  // canvas geometry, same as the block defaults
  localparam int CANVAS_WIDTH  = 256;
  localparam int CANVAS_HEIGHT = 128;
  localparam int ROW_BYTES     = (CANVAS_WIDTH + 7) / 8;
  localparam int CANVAS_BYTES  = ROW_BYTES * CANVAS_HEIGHT;
  localparam int SPAN_CAP      = 2048;

  // a clearing sweep plus a margin for the pixel steps covers the longest the block can stay busy
  localparam int SETTLE_CYCLES   = CANVAS_BYTES + 32;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_PCT        = 27;
  localparam int RANDOM_WORDS    = 80;

  // op 3 has no meaning in the block, it must be swallowed silently
  localparam logic [1:0] OP_NONE = 2'd3;
  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [11:0]          cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;  // pixel[15:0], read_addr[27:16], zero pad
  logic [1:0]           in_tuser   = '0;  // op[1:0]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;        // read_data[7:0], frame_update[8], fast_refresh[9]
  logic                 out_tuser;        // is_read

  rgb565_to_mono_canvas_writer #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // one result word as the block should emit it
  typedef struct packed {
    logic       is_read;
    logic [7:0] read_data;
    logic       frame_update;
    logic       fast_refresh;
  } canvas_reply_t;

  canvas_reply_t expected_replies[$];

  // shadow copy of the block state
  int         win_x0 = RST_X_START;
  int         win_y0 = RST_Y_START;
  int         win_x1 = RST_X_END;
  int         win_y1 = RST_Y_END;
  int         col_pos = 0;
  int         row_pos = 0;
  logic       fast_pending = 1'b0;
  logic [7:0] canvas_img [CANVAS_BYTES] = '{default: 8'hFF};

  int   error_count    = 0;
  int   words_sent     = 0;
  logic steady_flow    = 1'b0;  // both sides stop idling while set
  int   hold_serial    = 0;     // bumped to ask the receiver for a long hold-off
  int   hold_seen      = 0;
  int   hold_left      = 0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // weighted luma below the threshold is black; pure white and pure black bypass it
  function automatic logic pixel_is_dark(input logic [15:0] p);
    int luma;
    luma = int'(p[15:11]) * 2460 + int'(p[10:5]) * 2376 + int'(p[4:0]) * 938;
    if (p == 16'hFFFF) return 1'b0;
    if (p == 16'h0000) return 1'b1;
    return luma < 150000;
  endfunction

  // window extent along one axis, capped at the counter range
  function automatic int window_span(input int lo, input int hi);
    if (hi - lo <= 0) return 0;
    if (hi - lo > SPAN_CAP) return SPAN_CAP;
    return hi - lo;
  endfunction

  function automatic void apply_window_reg(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [11:0] value);
    logic known;
    known = 1'b1;
    case (idx)
      REG_X_START: win_x0 = int'($signed(value));
      REG_Y_START: win_y0 = int'($signed(value));
      REG_X_END:   win_x1 = int'($signed(value));
      REG_Y_END:   win_y1 = int'($signed(value));
      default:     known = 1'b0;
    endcase
    // any decoded write restarts the raster walk
    if (known) begin
      col_pos = 0;
      row_pos = 0;
    end
  endfunction

  // advance the shadow state by one accepted input word, queue its result if any
  function automatic void predict_canvas_reply(input logic [1:0] op, input logic [15:0] pixel,
                                               input logic [11:0] addr);
    int            w, h, px, py, idx;
    logic [7:0]    bit_mask;
    logic          window_done, full_frame;
    canvas_reply_t reply;
    reply = '0;
    case (op)
      OP_READ: begin
        reply.is_read   = 1'b1;
        reply.read_data = (int'(addr) < CANVAS_BYTES) ? canvas_img[addr] : 8'hFF;
        expected_replies.push_back(reply);
      end
      OP_FAST: fast_pending = 1'b1;
      OP_WRITE: begin
        w = window_span(win_x0, win_x1);
        h = window_span(win_y0, win_y1);
        // empty window drops the pixel outright
        if (w != 0 && h != 0) begin
          // first pixel of an origin-anchored window wipes the canvas to white
          if (col_pos == 0 && row_pos == 0 && win_x0 == 0 && win_y0 == 0)
            canvas_img = '{default: 8'hFF};
          px = win_x0 + col_pos;
          py = win_y0 + row_pos;
          // off-canvas pixels are clipped but still walk the counters
          if (px >= 0 && px < CANVAS_WIDTH && py >= 0 && py < CANVAS_HEIGHT) begin
            idx      = py * ROW_BYTES + px / 8;
            bit_mask = 8'h80 >> (px % 8);
            if (pixel_is_dark(pixel)) canvas_img[idx] = canvas_img[idx] & ~bit_mask;
            else canvas_img[idx] = canvas_img[idx] | bit_mask;
          end
          window_done = 1'b0;
          if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h) begin
              row_pos     = 0;
              window_done = 1'b1;
            end else begin
              row_pos++;
            end
          end else begin
            col_pos++;
          end
          if (window_done) begin
            full_frame = win_x0 <= 0 && win_x1 >= CANVAS_WIDTH && win_y1 >= CANVAS_HEIGHT;
            reply.frame_update = full_frame;
            reply.fast_refresh = full_frame && fast_pending;
            // only a real frame update consumes the fast arm
            if (full_frame) fast_pending = 1'b0;
            expected_replies.push_back(reply);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random ready, long hold-off on request
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_serial != hold_seen) begin
      hold_seen  <= hold_serial;
      hold_left  <= HOLD_OFF_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (steady_flow) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // compare every accepted result word against the oldest prediction
  always @(posedge clk) begin
    canvas_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result word: tuser %0b tdata %0h", out_tuser, out_tdata);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        if (out_tuser !== want.is_read) begin
          $error("is_read expected %0b got %0b", want.is_read, out_tuser);
          error_count++;
        end
        if (out_tdata[7:0] !== want.read_data) begin
          $error("read_data expected %02h got %02h", want.read_data, out_tdata[7:0]);
          error_count++;
        end
        if (out_tdata[8] !== want.frame_update) begin
          $error("frame_update expected %0b got %0b", want.frame_update, out_tdata[8]);
          error_count++;
        end
        if (out_tdata[9] !== want.fast_refresh) begin
          $error("fast_refresh expected %0b got %0b", want.fast_refresh, out_tdata[9]);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one input word, with random idle cycles ahead of it
  task automatic send_word(input logic [1:0] op, input logic [15:0] pixel,
                           input logic [11:0] addr);
    @(negedge clk);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, addr, pixel};
    do @(posedge clk); while (!in_tready);
    predict_canvas_reply(op, pixel, addr);
    if (op != OP_NONE) words_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_window_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering, wait for every owed result, then let any sweep or pixel finish
  task automatic drain_and_settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // program all four window registers, in a rotated order, on an idle block
  task automatic set_window(input int x0, input int y0, input int x1, input int y1);
    logic [CFG_IDX_W-1:0] regs [4];
    int                   vals [4];
    int                   first;
    regs  = '{REG_X_START, REG_Y_START, REG_X_END, REG_Y_END};
    vals  = '{x0, y0, x1, y1};
    first = $urandom_range(0, 3);
    drain_and_settle();
    for (int k = 0; k < 4; k++) cfg_write(regs[(first + k) % 4], 12'(vals[(first + k) % 4]));
  endtask

  // mostly random colors, with the shortcut values and both sides of the threshold
  function automatic logic [15:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h07E0 | 16'($urandom_range(0, 1));  // just below / above the limit
      default: return 16'($urandom());
    endcase
  endfunction

  // a byte address inside the on-canvas part of the window, or anywhere now and then
  function automatic logic [11:0] window_byte_addr();
    int lo_x, hi_x, lo_y, hi_y;
    lo_x = (win_x0 < 0) ? 0 : win_x0;
    lo_y = (win_y0 < 0) ? 0 : win_y0;
    hi_x = ((win_x1 > CANVAS_WIDTH) ? CANVAS_WIDTH : win_x1) - 1;
    hi_y = ((win_y1 > CANVAS_HEIGHT) ? CANVAS_HEIGHT : win_y1) - 1;
    if (lo_x > hi_x || lo_y > hi_y || $urandom_range(0, 3) == 0)
      return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(lo_y, hi_y) * ROW_BYTES + $urandom_range(lo_x, hi_x) / 8);
  endfunction

  task automatic read_window_bytes(input int count);
    for (int n = 0; n < count; n++) send_word(OP_READ, 16'($urandom()), window_byte_addr());
  endtask

  // raster pixels with reads, fast arms and dead ops mixed in
  task automatic send_pixels(input int count, input int noise_pct);
    int pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) send_word(OP_READ, 16'($urandom()), window_byte_addr());
        else if (pick < 8) send_word(OP_FAST, 16'($urandom()), 12'($urandom()));
        else send_word(OP_NONE, random_pixel(), 12'($urandom()));
      end
      send_word(OP_WRITE, random_pixel(), 12'($urandom()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // canvas is white after reset at both ends of the address range, dead op ignored
  task automatic test_after_reset();
    send_word(OP_READ, 16'h0000, 12'h000);
    send_word(OP_READ, 16'hFFFF, 12'(CANVAS_BYTES - 1));
    send_word(OP_NONE, 16'hFFFF, 12'hFFF);
    // armed here, held through the next done word since that one is no frame update
    send_word(OP_FAST, 16'h0000, 12'h000);
  endtask

  // anchored 4x2 window: clears first, then each color class lands in its bit
  task automatic test_pixel_classes();
    logic [15:0] colors [8];
    colors = '{16'h0000, 16'hFFFF, 16'h07E0, 16'h07E1, 16'hF81F, 16'hFFFE, 16'h0001, 16'h8000};
    set_window(0, 0, 4, 2);
    foreach (colors[i]) send_word(OP_WRITE, colors[i], 12'h000);
    send_word(OP_READ, 16'h0000, 12'h000);
    send_word(OP_READ, 16'h0000, 12'(ROW_BYTES));
  endtask

  // empty window drops pixels; undecoded register writes leave the walk alone
  task automatic test_empty_and_spare_regs();
    set_window(10, 10, 10, 12);
    send_word(OP_WRITE, 16'h0000, 12'h000);
    send_word(OP_WRITE, 16'h0000, 12'h000);
    send_word(OP_READ, 16'h0000, 12'(10 * ROW_BYTES + 1));
    set_window(3, 5, 6, 6);
    send_word(OP_WRITE, 16'h0000, 12'h000);
    send_word(OP_WRITE, 16'h0000, 12'h000);
    drain_and_settle();
    cfg_write(REG_SPARE_LO, 12'h800);
    cfg_write(REG_SPARE_HI, 12'h7FF);
    // third pixel still closes the 3x1 window
    send_word(OP_WRITE, 16'h0000, 12'h000);
    send_word(OP_READ, 16'h0000, 12'(5 * ROW_BYTES));
  endtask

  // bottom strips spanning the full width raise frame updates, fast then full
  task automatic test_frame_refresh();
    set_window(0, CANVAS_HEIGHT - 1, CANVAS_WIDTH, CANVAS_HEIGHT);
    // long run with neither side idling
    steady_flow = 1'b1;
    send_pixels(CANVAS_WIDTH, 0);
    steady_flow = 1'b0;
    send_pixels(CANVAS_WIDTH, 0);
    read_window_bytes(4);
    // starting right of column 0 is no frame update, armed fast must survive it
    set_window(1, CANVAS_HEIGHT - 1, CANVAS_WIDTH, CANVAS_HEIGHT);
    send_word(OP_FAST, 16'h0000, 12'h000);
    send_pixels(CANVAS_WIDTH - 1, 0);
    // clipped on both sides, closes with the surviving fast arm
    set_window(-3, CANVAS_HEIGHT - 1, CANVAS_WIDTH + 2, CANVAS_HEIGHT);
    send_pixels(CANVAS_WIDTH + 5, 5);
    read_window_bytes(4);
  endtask

  // widest possible register values: the capped walk must not close early
  task automatic test_oversized_window();
    set_window(-2048, CANVAS_HEIGHT - 1, 2047, CANVAS_HEIGHT);
    send_word(OP_FAST, 16'h0000, 12'h000);
    send_pixels(64, 2);
    read_window_bytes(6);
  endtask

  // receiver stops for a long time while reads keep coming, input must back up
  task automatic test_output_backpressure();
    set_window(8, 8, 40, 10);
    send_pixels(32 * 2, 0);
    hold_serial++;
    read_window_bytes(48);
  endtask

  // random windows: edges, anchored, full-width strips, far off-canvas registers, empty;
  // some walks are cut short and restarted by the next register write
  task automatic test_random_windows();
    int x0, y0, x1, y1, total, start_words;
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          x0 = $urandom_range(0, CANVAS_WIDTH + 8) - 8;
          y0 = $urandom_range(0, CANVAS_HEIGHT + 4) - 4;
          x1 = x0 + $urandom_range(1, 12);
          y1 = y0 + $urandom_range(1, 3);
        end
        4: begin
          x0 = 0;
          y0 = 0;
          x1 = $urandom_range(1, 16);
          y1 = $urandom_range(1, 2);
        end
        5: begin
          x0 = -$urandom_range(0, 3);
          y0 = CANVAS_HEIGHT - $urandom_range(1, 2);
          x1 = CANVAS_WIDTH + $urandom_range(0, 3);
          y1 = CANVAS_HEIGHT + $urandom_range(0, 1);
        end
        6: begin
          x0 = $urandom_range(0, 1) ? -1024 : 1020;
          y0 = $urandom_range(0, 1) ? -1024 : 1020;
          x1 = x0 + $urandom_range(1, 4);
          y1 = y0 + $urandom_range(1, 4);
        end
        7: begin
          x0 = $urandom_range(0, CANVAS_WIDTH);
          y0 = $urandom_range(0, CANVAS_HEIGHT);
          x1 = $urandom_range(0, 1) ? x0 - $urandom_range(0, 3) : x0 + 2;
          y1 = (x1 > x0) ? y0 - $urandom_range(0, 3) : y0 + 2;
        end
        default: begin
          x0 = $urandom_range(0, CANVAS_WIDTH - 8);
          y0 = $urandom_range(0, CANVAS_HEIGHT - 3);
          x1 = x0 + $urandom_range(1, 8);
          y1 = y0 + $urandom_range(1, 3);
        end
      endcase
      set_window(x0, y0, x1, y1);
      total = window_span(x0, x1) * window_span(y0, y1);
      if (total == 0) total = $urandom_range(1, 4);
      else if ($urandom_range(0, 99) < 15) total = $urandom_range(0, total - 1);
      if ($urandom_range(0, 3) == 0) send_word(OP_FAST, 16'($urandom()), 12'($urandom()));
      send_pixels(total, 10);
      read_window_bytes(2);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_pixel_classes();
    test_empty_and_spare_regs();
    test_frame_refresh();
    test_oversized_window();
    test_output_backpressure();
    test_random_windows();
    drain_and_settle();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
